/* rtl/tdfm_pkg.sv */
// Shared types, constants and a row helper for the tile dedup block.
package tdfm_pkg;

    localparam int MAX_TILES = 256;
    localparam int IDX_W     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CNT_W     = 12;
    localparam int ENTRY_W   = 11;
    localparam int ROW_W     = 32;
    localparam int ROWS      = 8;
    localparam int NIB       = 4;
    localparam logic [2:0] ROW_LAST = 3'd7;

    typedef logic [ROWS-1:0][ROW_W-1:0] t_tile;

    typedef struct packed {
        logic m_plain;
        logic m_v;
        logic m_vh;
        logic m_h;
    } t_hit;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_index;
        logic               vflip;
        logic               hflip;
        logic               is_new;
        logic               table_full;
        logic [CNT_W-1:0]   tile_count;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DONE   = 3'b100
    } t_state;

    function automatic logic [ROW_W-1:0] mirror_row(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] o;
        for (int k = 0; k < ROW_W / NIB; k++) begin
            o[k*NIB +: NIB] = r[ROW_W - NIB - k*NIB +: NIB];
        end
        return o;
    endfunction

endpackage

/* rtl/tdfm_in_if.sv */
// Request channel: tile row data or clear command.
interface tdfm_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] row_bits;

    modport source(output valid, output cmd, output row_bits, input ready);
    modport sink(input valid, input cmd, input row_bits, output ready);
endinterface

/* rtl/tdfm_out_if.sv */
// Result channel: plane entry for a finished tile.
interface tdfm_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] entry_index;
    logic        vflip;
    logic        hflip;
    logic        is_new;
    logic        table_full;
    logic [11:0] tile_count;

    modport source(output valid, output entry_index, output vflip, output hflip,
                   output is_new, output table_full, output tile_count, input ready);
    modport sink(input valid, input entry_index, input vflip, input hflip,
                 input is_new, input table_full, input tile_count, output ready);
endinterface

/* rtl/tdfm_match.sv */
// Four-way flip compare of one stored tile against the buffered tile.
module tdfm_match (
    input  tdfm_pkg::t_tile i_entry,
    input  tdfm_pkg::t_tile i_tile,
    output tdfm_pkg::t_hit  o_hit
);
    import tdfm_pkg::*;

    logic [ROWS-1:0] eq_plain, eq_v, eq_vh, eq_h;

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            eq_plain[r] = (i_entry[r] == i_tile[r]);
            eq_v[r]     = (i_entry[ROWS-1-r] == i_tile[r]);
            eq_vh[r]    = (mirror_row(i_entry[ROWS-1-r]) == i_tile[r]);
            eq_h[r]     = (mirror_row(i_entry[r]) == i_tile[r]);
        end
        o_hit.m_plain = &eq_plain;
        o_hit.m_v     = &eq_v;
        o_hit.m_vh    = &eq_vh;
        o_hit.m_h     = &eq_h;
    end

endmodule

/* rtl/tile_dedup_flip_match.sv */
// Tile deduplicator with flip matching: row collection, tileset search, append.
//
//   channel   dir   handshake        payload
//   i_req     in    valid / ready    cmd, row_bits
//   o_rsp     out   valid / ready    entry_index, vflip, hflip, is_new,
//                                    table_full, tile_count
//
// Rows and clear commands are taken while idle. The eighth row starts a search that
// reads one whole tile per cycle from the tileset memory: the first matching entry
// ends it, and with no match it ends once every stored tile has been compared. The
// result then passes through the done state to the output register, and waits while
// it is full. No request is taken from the eighth row until the result has moved.
// Reset empties the tileset count; memory contents need no clearing.
module tile_dedup_flip_match (
    input logic        i_clk,
    input logic        i_rst_n,
    tdfm_in_if.sink    i_req,
    tdfm_out_if.source o_rsp
);
    import tdfm_pkg::*;

    t_state           r_state, n_state;
    t_tile            r_rows, n_rows;
    logic [2:0]       r_row_cnt, n_row_cnt;
    logic [CNT_W-1:0] r_stored, n_stored;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    t_res             r_res, n_res;
    logic             r_out_vld, n_out_vld;
    t_res             r_out, n_out;

    t_tile            r_tile_mem [MAX_TILES];
    t_tile            r_mem_q;
    logic             rd_en, wr_en;
    t_hit             hit;

    tdfm_match u_match (
        .i_entry (r_mem_q),
        .i_tile  (r_rows),
        .o_hit   (hit)
    );

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mem_q <= r_tile_mem[r_rd_idx[IDX_W-1:0]];
        end
        if (wr_en) begin
            r_tile_mem[r_stored[IDX_W-1:0]] <= r_rows;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_rows    = r_rows;
        n_row_cnt = r_row_cnt;
        n_stored  = r_stored;
        n_rd_idx  = r_rd_idx;
        n_rd_vld  = r_rd_vld;
        n_cmp_idx = r_cmp_idx;
        n_res     = r_res;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        rd_en     = 1'b0;
        wr_en     = 1'b0;

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.cmd) begin
                        n_stored  = '0;
                        n_row_cnt = '0;
                    end else begin
                        n_rows[r_row_cnt] = i_req.row_bits;
                        n_row_cnt         = r_row_cnt + 3'd1;
                        if (r_row_cnt == ROW_LAST) begin
                            n_state  = S_SEARCH;
                            n_rd_idx = '0;
                            n_rd_vld = 1'b0;
                        end
                    end
                end
            end
            S_SEARCH: begin
                if (r_rd_vld && (|hit)) begin
                    n_res.entry_index = ENTRY_W'(r_cmp_idx);
                    n_res.is_new      = 1'b0;
                    n_res.table_full  = 1'b0;
                    n_res.tile_count  = r_stored;
                    priority if (hit.m_plain) begin
                        n_res.vflip = 1'b0;
                        n_res.hflip = 1'b0;
                    end else if (hit.m_v) begin
                        n_res.vflip = 1'b1;
                        n_res.hflip = 1'b0;
                    end else if (hit.m_vh) begin
                        n_res.vflip = 1'b1;
                        n_res.hflip = 1'b1;
                    end else begin
                        n_res.vflip = 1'b0;
                        n_res.hflip = 1'b1;
                    end
                    n_rd_vld = 1'b0;
                    n_state  = S_DONE;
                end else if (r_rd_idx < r_stored) begin
                    rd_en     = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_cmp_idx = r_rd_idx[IDX_W-1:0];
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                end else if (r_rd_vld) begin
                    n_rd_vld = 1'b0;
                end else begin
                    n_res.vflip = 1'b0;
                    n_res.hflip = 1'b0;
                    if (r_stored < CNT_W'(MAX_TILES)) begin
                        wr_en             = 1'b1;
                        n_res.entry_index = r_stored[ENTRY_W-1:0];
                        n_res.is_new      = 1'b1;
                        n_res.table_full  = 1'b0;
                        n_stored          = r_stored + CNT_W'(1);
                        n_res.tile_count  = r_stored + CNT_W'(1);
                    end else begin
                        n_res.entry_index = '0;
                        n_res.is_new      = 1'b0;
                        n_res.table_full  = 1'b1;
                        n_res.tile_count  = r_stored;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_cnt <= '0;
            r_stored  <= '0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row_cnt <= n_row_cnt;
            r_stored  <= n_stored;
            r_rd_idx  <= n_rd_idx;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows    <= n_rows;
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.entry_index = r_out.entry_index;
    assign o_rsp.vflip       = r_out.vflip;
    assign o_rsp.hflip       = r_out.hflip;
    assign o_rsp.is_new      = r_out.is_new;
    assign o_rsp.table_full  = r_out.table_full;
    assign o_rsp.tile_count  = r_out.tile_count;

endmodule

/* rtl/tdfm_checker.sv */
// Port-level checks for the tile dedup block, bound to the top level.
module tdfm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [10:0] i_entry_index,
    input logic        i_vflip,
    input logic        i_hflip,
    input logic        i_is_new,
    input logic        i_table_full,
    input logic [11:0] i_tile_count
);
    import tdfm_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_entry_index) && $stable(i_tile_count))
        else $error("result changed while stalled");

    a_new_no_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_is_new || i_table_full) |-> !i_vflip && !i_hflip
            && !(i_is_new && i_table_full))
        else $error("flip flags on an unmatched tile");

    a_new_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_is_new |-> i_tile_count == {1'b0, i_entry_index} + 12'd1)
        else $error("new tile index does not follow count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_tile_count <= 12'(MAX_TILES)
            && (!i_table_full || i_tile_count == 12'(MAX_TILES)))
        else $error("tile count out of range");

endmodule

bind tile_dedup_flip_match tdfm_checker u_tdfm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_entry_index (o_rsp.entry_index),
    .i_vflip       (o_rsp.vflip),
    .i_hflip       (o_rsp.hflip),
    .i_is_new      (o_rsp.is_new),
    .i_table_full  (o_rsp.table_full),
    .i_tile_count  (o_rsp.tile_count)
);

/* tb/testbench.sv */
// Testbench for tile_dedup_flip_match: tile traffic with a scoreboard that predicts each entry.
`timescale 1ns / 1ps

module testbench;
    import tdfm_pkg::*;

    localparam logic CMD_ROW   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam int   IDLE_LIMIT = 4000;
    localparam int   TAIL_CYCLES = MAX_TILES + 20;

    typedef enum logic [1:0] {
        FLIP_NONE = 2'b00,
        FLIP_H    = 2'b01,
        FLIP_V    = 2'b10,
        FLIP_VH   = 2'b11
    } t_flip;

    localparam t_flip SEARCH_ORDER [4] = '{FLIP_NONE, FLIP_V, FLIP_VH, FLIP_H};
    localparam logic [31:0] ROW_POOL [6] = '{32'h00000000, 32'hFFFFFFFF, 32'h0F0F0F0F,
                                             32'hF0F0F0F0, 32'h13572468, 32'h86427531};

    class tile_scoreboard;
        t_tile       store [MAX_TILES];
        t_tile       rows;
        logic [2:0]  row_idx = '0;
        int          count = 0;
        t_res        pending [$];
        int          errors = 0;

        function logic [31:0] rev_nibbles(logic [31:0] r);
            logic [31:0] o;
            for (int k = 0; k < 8; k++) begin
                o[4*k +: 4] = r[28 - 4*k +: 4];
            end
            return o;
        endfunction

        function t_tile apply_flip(t_tile t, t_flip m);
            t_tile       o;
            logic [31:0] src;
            for (int r = 0; r < ROWS; r++) begin
                src = m[1] ? t[ROWS-1-r] : t[r];
                o[r] = m[0] ? rev_nibbles(src) : src;
            end
            return o;
        endfunction

        function void note_request(logic c, logic [31:0] r);
            t_res want;
            bit   hit;
            int   i;
            int   k;
            if (c == CMD_CLEAR) begin
                count   = 0;
                row_idx = '0;
            end else begin
                rows[row_idx] = r;
                if (row_idx != ROW_LAST) begin
                    row_idx++;
                end else begin
                    row_idx = '0;
                    want = '0;
                    hit  = 1'b0;
                    for (i = 0; i < count && !hit; i++) begin
                        for (k = 0; k < 4 && !hit; k++) begin
                            if (apply_flip(store[i], SEARCH_ORDER[k]) == rows) begin
                                hit              = 1'b1;
                                want.entry_index = ENTRY_W'(i);
                                want.vflip       = SEARCH_ORDER[k][1];
                                want.hflip       = SEARCH_ORDER[k][0];
                                want.tile_count  = CNT_W'(count);
                            end
                        end
                    end
                    if (!hit) begin
                        if (count < MAX_TILES) begin
                            store[count]     = rows;
                            want.entry_index = ENTRY_W'(count);
                            want.is_new      = 1'b1;
                            count++;
                        end else begin
                            want.table_full = 1'b1;
                        end
                        want.tile_count = CNT_W'(count);
                    end
                    pending.push_back(want);
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result with no request pending, index %0d",
                                          got.entry_index));
            end else begin
                want = pending.pop_front();
                if (got.entry_index !== want.entry_index)
                    report_mismatch($sformatf("entry_index got %0d exp %0d",
                                              got.entry_index, want.entry_index));
                if (got.vflip !== want.vflip)
                    report_mismatch($sformatf("vflip got %b exp %b", got.vflip, want.vflip));
                if (got.hflip !== want.hflip)
                    report_mismatch($sformatf("hflip got %b exp %b", got.hflip, want.hflip));
                if (got.is_new !== want.is_new)
                    report_mismatch($sformatf("is_new got %b exp %b", got.is_new, want.is_new));
                if (got.table_full !== want.table_full)
                    report_mismatch($sformatf("table_full got %b exp %b",
                                              got.table_full, want.table_full));
                if (got.tile_count !== want.tile_count)
                    report_mismatch($sformatf("tile_count got %0d exp %0d",
                                              got.tile_count, want.tile_count));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tdfm_in_if  req_if ();
    tdfm_out_if rsp_if ();

    tile_dedup_flip_match u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    tile_scoreboard sb = new;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int rx_wait  = 0;
    int idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    // result side: random back-pressure, burst stretches with ready held high
    always @(posedge i_clk) begin
        t_res got;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rx_wait = 0;
        end else if (rsp_if.valid && rsp_if.ready) begin
            got.entry_index = rsp_if.entry_index;
            got.vflip       = rsp_if.vflip;
            got.hflip       = rsp_if.hflip;
            got.is_new      = rsp_if.is_new;
            got.table_full  = rsp_if.table_full;
            got.tile_count  = rsp_if.tile_count;
            sb.check_result(got);
            if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 17);
            rsp_if.ready <= (rx_wait == 0);
        end else if (rsp_if.valid) begin
            if (rx_wait > 0) rx_wait--;
            if (rx_wait == 0) rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_req(input logic c, input logic [31:0] r);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.cmd      <= c;
        req_if.row_bits <= r;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(c, r);
    endtask

    task automatic send_tile(input t_tile t);
        for (int r = 0; r < ROWS; r++) begin
            send_req(CMD_ROW, t[r]);
        end
    endtask

    // partial tile cut short by a clear
    task automatic send_broken(input t_tile t, input int n_rows);
        for (int r = 0; r < n_rows; r++) begin
            send_req(CMD_ROW, t[r]);
        end
        send_req(CMD_CLEAR, $urandom());
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    task automatic make_tile(input int fresh_pct, output t_tile t);
        int          roll;
        logic [31:0] a;
        logic [31:0] b;
        bit          vsym;
        bit          hsym;
        roll = $urandom_range(0, 99);
        if (roll < fresh_pct || sb.count == 0) begin
            for (int r = 0; r < ROWS; r++) t[r] = $urandom();
        end else if (roll < fresh_pct + (100 - fresh_pct) / 2) begin
            t = sb.apply_flip(sb.store[$urandom_range(0, sb.count - 1)],
                              t_flip'($urandom_range(0, 3)));
        end else if (roll % 2 == 0) begin
            // few distinct rows, so flipped copies turn up often
            a = ROW_POOL[$urandom_range(0, 5)];
            b = ROW_POOL[$urandom_range(0, 5)];
            for (int r = 0; r < ROWS; r++) t[r] = $urandom_range(0, 1) ? a : b;
        end else begin
            // symmetric tiles exercise the search order
            vsym = $urandom_range(0, 1);
            hsym = !vsym || ($urandom_range(0, 1) == 1);
            for (int r = 0; r < ROWS; r++) begin
                a = $urandom();
                if (hsym) begin
                    b       = sb.rev_nibbles(a);
                    a[15:0] = b[15:0];
                end
                t[r] = a;
            end
            if (vsym) begin
                for (int r = 0; r < ROWS / 2; r++) t[ROWS-1-r] = t[r];
            end
        end
    endtask

    initial begin
        t_tile tile;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.cmd      = CMD_ROW;
        req_if.row_bits = '0;
        rsp_if.ready    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: new tile, its double flip, then a clear in mid-tile
        tile[0] = 32'h00000000;
        tile[1] = 32'hFFFFFFFF;
        tile[2] = 32'h01234567;
        tile[3] = 32'h89ABCDEF;
        tile[4] = 32'hFEDCBA98;
        tile[5] = 32'h76543210;
        tile[6] = 32'h0000FFFF;
        tile[7] = 32'h12345678;
        send_tile(tile);
        send_tile(sb.apply_flip(tile, FLIP_VH));
        send_broken(tile, 3);

        repeat (10) begin
            make_tile(40, tile);
            if ($urandom_range(0, 11) == 0) send_broken(tile, $urandom_range(0, 7));
            else send_tile(tile);
        end

        // let the block go quiet, then fill the tileset to the top
        drain_results();
        send_req(CMD_CLEAR, $urandom());
        while (sb.count < MAX_TILES) begin
            make_tile(90, tile);
            send_tile(tile);
        end

        repeat (10) begin
            make_tile(40, tile);
            send_tile(tile);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
